FILE: rtl/core/mlmr_pkg.sv
// -----------------------------------------------------------------------------
// mlmr_pkg
// Shared types, field widths and codes of the loop mixer and recorder.
// -----------------------------------------------------------------------------
package mlmr_pkg;

	localparam int MAX_LOOPS_DEF    = 16;
	localparam int MAX_LOOP_LEN_DEF = 16384;

	localparam int KIND_W     = 2;
	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 16;
	localparam int IDX_W      = 4;
	localparam int ACTIVE_W   = 5;
	localparam int LENGTH_W   = 15;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_BITS  = 15;
	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOOPS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH  = CFG_IDX_W'(1);

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK      = 2'd0,
		KIND_LEVEL     = 2'd1,
		KIND_REC_START = 2'd2,
		KIND_REC_STOP  = 2'd3
	} item_kind_t;

	typedef enum logic {
		JOB_TICK,
		JOB_LEVEL
	} job_op_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_MIX,
		BK_DRAIN,
		BK_DONE
	} back_state_t;

endpackage

FILE: rtl/core/mlmr_if.sv
// -----------------------------------------------------------------------------
// mlmr_if
// Valid/ready channels of the loop mixer: input items, results, register writes.
// -----------------------------------------------------------------------------
interface mlmr_in_if
	import mlmr_pkg::*;
	();
	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic signed [SAMPLE_W-1:0] in_sample;
	logic [IDX_W-1:0]           loop_index;
	logic [LEVEL_W-1:0]         level;

	modport source (output valid, kind, in_sample, loop_index, level, input ready);
	modport sink (input valid, kind, in_sample, loop_index, level, output ready);
endinterface

interface mlmr_out_if
	import mlmr_pkg::*;
	();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] mixed_sample;

	modport source (output valid, mixed_sample, input ready);
	modport sink (input valid, mixed_sample, output ready);
endinterface

interface mlmr_cfg_if
	import mlmr_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/multitrack_loop_mixer_recorder.sv
// -----------------------------------------------------------------------------
// multitrack_loop_mixer_recorder
// Mono multitrack looper: mixes stored loops at the play position and records
// the input into the armed loop.
// -----------------------------------------------------------------------------
// After reset the sample memory is zeroed, one word a cycle, over all
// 2**(clog2(MAX_LOOPS) + clog2(MAX_LOOP_LEN)) words (262144 at the defaults);
// no item is taken during that time, register writes are. Start and stop
// recording bypass the job queue and apply to every tick accepted after them.
// Audio ticks and level changes wait in a two-entry job queue; a level change
// is applied when popped; an audio tick mixes the N effective loops, and
// the single read port of the sample memory delivers one loop's sample per
// cycle into the multiply-accumulate.
// A finished result sits in an output register while the next job runs.
module multitrack_loop_mixer_recorder import mlmr_pkg::*; #(
	parameter int MAX_LOOPS    = MAX_LOOPS_DEF,
	parameter int MAX_LOOP_LEN = MAX_LOOP_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mlmr_in_if.sink    item,
	mlmr_out_if.source result,
	mlmr_cfg_if.sink   cfg
);

	localparam int LW = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;
	localparam int PW = $clog2(MAX_LOOP_LEN);
	localparam int NW = $clog2(MAX_LOOPS + 1);

	typedef struct packed {
		job_op_t                    op;
		logic [PW-1:0]              pos;
		logic [NW-1:0]              n;
		logic                       rec_en;
		logic [LW-1:0]              rec_loop;
		logic signed [SAMPLE_W-1:0] sample;
		logic [IDX_W-1:0]           idx;
		logic [LEVEL_W-1:0]         level;
	} job_t;

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	logic clearing;
	job_t push_job;
	job_t head_job;

	mlmr_front #(
		.job_t        (job_t),
		.MAX_LOOPS    (MAX_LOOPS),
		.MAX_LOOP_LEN (MAX_LOOP_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg),
		.clearing (clearing),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	mlmr_queue #(
		.job_t (job_t),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_job),
		.full   (q_full),
		.pop    (pop),
		.dout   (head_job),
		.empty  (q_empty)
	);

	mlmr_back #(
		.job_t        (job_t),
		.MAX_LOOPS    (MAX_LOOPS),
		.MAX_LOOP_LEN (MAX_LOOP_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head_job),
		.pop      (pop),
		.clearing (clearing),
		.result   (result)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job popped from an empty queue");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !(item.valid && item.ready))
		else $error("item accepted during memory clear");

endmodule

FILE: rtl/core/mlmr_ram.sv
// -----------------------------------------------------------------------------
// mlmr_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module mlmr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/mlmr_queue.sv
// -----------------------------------------------------------------------------
// mlmr_queue
// Short job queue between the front and back parts.
// -----------------------------------------------------------------------------
module mlmr_queue import mlmr_pkg::*; #(
	parameter type job_t = logic,
	parameter int  DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output job_t dout,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/mlmr_front.sv
// -----------------------------------------------------------------------------
// mlmr_front
// Accepts and classifies items, keeps position, record and config state,
// and queues tick and level jobs for the back part.
// -----------------------------------------------------------------------------
module mlmr_front import mlmr_pkg::*; #(
	parameter type job_t        = logic,
	parameter int  MAX_LOOPS    = MAX_LOOPS_DEF,
	parameter int  MAX_LOOP_LEN = MAX_LOOP_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mlmr_in_if.sink  item,
	mlmr_cfg_if.sink cfg,
	input  logic clearing,
	input  logic q_full,
	output logic push,
	output job_t job
);

	localparam int LW    = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;
	localparam int PW    = $clog2(MAX_LOOP_LEN);
	localparam int NW    = $clog2(MAX_LOOPS + 1);
	localparam int LEN_W = $clog2(MAX_LOOP_LEN + 1);
	localparam int AW5   = (NW > ACTIVE_W) ? NW : ACTIVE_W;
	localparam int IXW   = (NW > IDX_W) ? NW : IDX_W;
	localparam int CW0   = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
	localparam int CW    = (CW0 > LENGTH_W) ? CW0 : LENGTH_W;

	logic [ACTIVE_W-1:0] act_q;
	logic [LENGTH_W-1:0] len_q;
	logic [PW-1:0]       pos_q;
	logic [IDX_W-1:0]    last_q;
	logic                rec_q;
	logic [IDX_W-1:0]    tgt_q;

	logic [NW-1:0] eff_n;
	logic [CW-1:0] eff_len;
	logic [CW-1:0] pos_inc;
	logic [PW-1:0] pos_nxt;
	logic          idx_ok;
	logic          tgt_ok;
	logic          accept;
	item_kind_t    kind;

	assign cfg.ready  = 1'b1;
	assign item.ready = !clearing && !q_full;
	assign accept     = item.valid && item.ready;
	assign kind       = item_kind_t'(item.kind);

	always_comb begin
		if (AW5'(act_q) > AW5'(MAX_LOOPS)) begin
			eff_n = NW'(MAX_LOOPS);
		end else begin
			eff_n = NW'(act_q);
		end
		if (len_q == '0) begin
			eff_len = CW'(1);
		end else if (CW'(len_q) > CW'(MAX_LOOP_LEN)) begin
			eff_len = CW'(MAX_LOOP_LEN);
		end else begin
			eff_len = CW'(len_q);
		end
		pos_inc = CW'(pos_q) + CW'(1);
		pos_nxt = (pos_inc >= eff_len) ? '0 : pos_inc[PW-1:0];
		idx_ok  = IXW'(item.loop_index) < IXW'(eff_n);
		tgt_ok  = IXW'(tgt_q) < IXW'(eff_n);
	end

	always_comb begin
		job          = '0;
		job.op       = (kind == KIND_TICK) ? JOB_TICK : JOB_LEVEL;
		job.pos      = pos_nxt;
		job.n        = eff_n;
		job.rec_en   = rec_q && tgt_ok;
		job.rec_loop = LW'(tgt_q);
		job.sample   = item.in_sample;
		job.idx      = item.loop_index;
		job.level    = item.level;
		push = accept && ((kind == KIND_TICK) || ((kind == KIND_LEVEL) && idx_ok));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= ACTIVE_W'(MAX_LOOPS_DEF);
			len_q  <= LENGTH_W'(MAX_LOOP_LEN_DEF);
			pos_q  <= '0;
			last_q <= '0;
			rec_q  <= 1'b0;
			tgt_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_ACTIVE_LOOPS) begin
					act_q <= cfg.data[ACTIVE_W-1:0];
				end else if (cfg.index == REG_LOOP_LENGTH) begin
					len_q <= cfg.data[LENGTH_W-1:0];
				end
			end
			if (accept) begin
				unique case (kind)
					KIND_TICK: begin
						pos_q <= pos_nxt;
					end
					KIND_LEVEL: begin
						if (idx_ok && (item.level != '0)) begin
							last_q <= item.loop_index;
						end
					end
					KIND_REC_START: begin
						rec_q <= 1'b1;
						tgt_q <= last_q;
					end
					KIND_REC_STOP: begin
						rec_q <= 1'b0;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/mlmr_back.sv
// -----------------------------------------------------------------------------
// mlmr_back
// Runs queued jobs: level table updates, per-loop multiply-accumulate over
// the sample memory, saturation, record write and the result register.
// -----------------------------------------------------------------------------
module mlmr_back import mlmr_pkg::*; #(
	parameter type job_t        = logic,
	parameter int  MAX_LOOPS    = MAX_LOOPS_DEF,
	parameter int  MAX_LOOP_LEN = MAX_LOOP_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  job_t head,
	output logic pop,
	output logic clearing,
	mlmr_out_if.source result
);

	localparam int LW    = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;
	localparam int PW    = $clog2(MAX_LOOP_LEN);
	localparam int NW    = $clog2(MAX_LOOPS + 1);
	localparam int AW    = LW + PW;
	localparam int LVN   = (MAX_LOOPS < 16) ? MAX_LOOPS : 16;
	localparam int IW    = (LVN > 1) ? $clog2(LVN) : 1;
	localparam int PRW   = SAMPLE_W + LEVEL_W + 1;
	localparam int ACC_W = PRW + $clog2(MAX_LOOPS) + 1;

	back_state_t state_q, state_d;

	job_t                       job_q;
	logic [LEVEL_W-1:0]         lvl_q [LVN];
	logic [LW-1:0]              k_q;
	logic [AW-1:0]              clr_q;
	logic                       vld_s1;
	logic signed [LEVEL_W:0]    lvl_s1;
	logic                       vld_s2;
	logic signed [PRW-1:0]      prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       res_vld_q;
	logic signed [SAMPLE_W-1:0] res_q;

	logic                       we;
	logic [AW-1:0]              waddr;
	logic [SAMPLE_W-1:0]        wdata;
	logic [AW-1:0]              raddr;
	logic [SAMPLE_W-1:0]        rdata;
	logic                       issue;
	logic                       res_load;
	logic                       k_last;
	logic [LEVEL_W-1:0]         lvl_sel;
	logic signed [ACC_W-1:0]    acc_sh;
	logic signed [SAMPLE_W-1:0] sat;

	mlmr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (1 << AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign raddr               = {k_q, job_q.pos};
	assign k_last              = (NW'(k_q) + NW'(1)) == job_q.n;
	assign result.valid        = res_vld_q;
	assign result.mixed_sample = res_q;

	always_comb begin
		lvl_sel = '0;
		if (int'(k_q) < LVN) begin
			lvl_sel = lvl_q[k_q[IW-1:0]];
		end
		acc_sh = acc_q >>> FRAC_BITS;
		if (acc_sh > ACC_W'(SAMPLE_MAX)) begin
			sat = SAMPLE_W'(SAMPLE_MAX);
		end else if (acc_sh < ACC_W'(SAMPLE_MIN)) begin
			sat = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			sat = acc_sh[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		clearing = 1'b0;
		we       = 1'b0;
		waddr    = clr_q;
		wdata    = '0;
		issue    = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				clearing = 1'b1;
				we       = 1'b1;
				if (clr_q == '1) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (head.op == JOB_TICK) begin
						state_d = (head.n == '0) ? BK_DONE : BK_MIX;
					end
				end
			end
			BK_MIX: begin
				issue = 1'b1;
				if (k_last) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!res_vld_q || result.ready) begin
					res_load = 1'b1;
					state_d  = BK_IDLE;
					if (job_q.rec_en) begin
						we    = 1'b1;
						waddr = {job_q.rec_loop, job_q.pos};
						wdata = job_q.sample;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			res_vld_q <= 1'b0;
			for (int i = 0; i < LVN; i++) begin
				lvl_q[i] <= '0;
			end
		end else begin
			if (clearing) begin
				clr_q <= clr_q + AW'(1);
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (pop && (head.op == JOB_LEVEL)) begin
				lvl_q[head.idx[IW-1:0]] <= head.level;
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.op == JOB_TICK)) begin
			job_q <= head;
			k_q   <= '0;
			acc_q <= '0;
		end else begin
			if (issue) begin
				k_q <= k_q + LW'(1);
			end
			if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		lvl_s1  <= $signed({1'b0, lvl_sel});
		prod_s2 <= $signed(rdata) * lvl_s1;
		if (res_load) begin
			res_q <= sat;
		end
	end

endmodule
